// File: hw/rtl/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// shared types, constants, sign extension and saturation helpers of the
// distance constraint projection unit
// ----------------------------------------------------------------------------
`default_nettype none

package dcp_pkg;

   // field and register widths
   localparam int DATA_W      = 32;
   localparam int REG_W       = 31;
   localparam int COORD_W_DEF = 32;

   // datapath widths
   localparam int ROOT_W = 33;          // floor sqrt of a 65-bit sum of squares
   localparam int RAD_W  = 2 * ROOT_W;  // radicand, top bit always zero
   localparam int MAG_W  = 34;          // widest magnitude seen by saturation
   localparam int U_QW   = 31;          // direction component, Q1.30 magnitude
   localparam int A1_QW  = 48;          // |nd| * 2^16 / dt
   localparam int A2_QW  = 32;          // second divide by dt, overflow checked

   // register reset values
   localparam logic [REG_W-1:0] REST_LENGTH_RST = 31'd65536;
   localparam logic [REG_W-1:0] TIME_STEP_RST   = 31'd1092;

   typedef enum logic [0:0] {
      CSR_REST_LENGTH = 1'b0,
      CSR_TIME_STEP   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_a_x;
      logic signed [DATA_W-1:0] pos_a_y;
      logic signed [DATA_W-1:0] pos_b_x;
      logic signed [DATA_W-1:0] pos_b_y;
      logic                     a_fixed;
      logic                     b_fixed;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] move_a_x;
      logic signed [DATA_W-1:0] move_a_y;
      logic signed [DATA_W-1:0] move_b_x;
      logic signed [DATA_W-1:0] move_b_y;
      logic signed [DATA_W-1:0] accel_a_x;
      logic signed [DATA_W-1:0] accel_a_y;
      logic signed [DATA_W-1:0] accel_b_x;
      logic signed [DATA_W-1:0] accel_b_y;
      logic                     degenerate;
   } rsp_type;

   // sign extend from the low cw bits
   function automatic logic signed [DATA_W-1:0] sext(input logic [DATA_W-1:0] x,
                                                      input int cw);
      logic [DATA_W-1:0] t;
      int                sh;
      sh = DATA_W - cw;
      t  = x << sh;
      return $signed(t) >>> sh;
   endfunction

   // clip a magnitude to the cw-bit signed range of the given sign
   function automatic logic [MAG_W-1:0] sat_mag(input logic neg,
                                                input logic [MAG_W-1:0] mag,
                                                input int cw);
      logic [MAG_W-1:0] lim;
      lim = {{(MAG_W-1){1'b0}}, 1'b1} << (cw - 1);
      if (!neg) begin
         lim = lim - {{(MAG_W-1){1'b0}}, 1'b1};
      end
      return (mag > lim) ? lim : mag;
   endfunction

   // sign and clipped magnitude to two's complement
   function automatic logic [DATA_W-1:0] to_val(input logic neg,
                                                input logic [MAG_W-1:0] mag);
      logic [DATA_W-1:0] m;
      m = mag[DATA_W-1:0];
      return neg ? ({DATA_W{1'b0}} - m) : m;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/distance_constraint_projection_unit.sv
// ----------------------------------------------------------------------------
// distance_constraint_projection_unit
// stages: 4 front stages, 33 root stages, 31 + 48 + 32 divider stages and
// 5 glue stages lie between the accepting edge and the result strobe
// throughput: one request per cycle; busy stays low, every stage is a plain
// register stage and the receiver cannot stall, so nothing ever waits
// reset: synchronous, clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module distance_constraint_projection_unit #(
   parameter int COORD_WIDTH = dcp_pkg::COORD_W_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     start,
   output logic                     busy,
   input  dcp_pkg::req_type         req_data,
   // result channel
   output logic                     rsp_valid,
   output dcp_pkg::rsp_type         rsp_data,
   // register writes
   input  logic                     csr_write_en,
   input  dcp_pkg::csr_idx_type     csr_index,
   input  logic [dcp_pkg::REG_W-1:0] csr_data
);

   // effective coordinate width, clamped to 16..32
   localparam int CW = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
   localparam int LATENCY = 4 + dcp_pkg::ROOT_W + 1 + dcp_pkg::U_QW + 2
                            + dcp_pkg::A1_QW + 1 + dcp_pkg::A2_QW + 1;

   // sideband bundles carried past the long units
   typedef struct packed {
      logic [31:0] mag_x;
      logic [31:0] mag_y;
      logic        neg_x;
      logic        neg_y;
      logic        a_fixed;
      logic        b_fixed;
   } sq_side_type;

   typedef struct packed {
      logic [33:0] diff_mag;
      logic        diff_neg;
      logic        neg_x;
      logic        a_fixed;
      logic        b_fixed;
      logic        degenerate;
   } ux_side_type;

   typedef struct packed {
      logic nd_neg_x;
      logic nd_neg_y;
      logic a_fixed;
      logic b_fixed;
      logic degenerate;
   } flag_type;

   typedef struct packed {
      logic [31:0] nd_mag_x;
      flag_type    flags;
   } a1_side_type;

   typedef struct packed {
      logic [31:0] nd_mag_x;
      flag_type    flags;
      logic        ovf_x;
   } a2_side_type;

   typedef struct packed {
      logic [31:0] nd_mag_y;
      logic        ovf_y;
   } a2y_side_type;

   typedef struct packed {
      logic [31:0] half_a;
      logic [31:0] half_b;
      logic [31:0] full_a;
      logic [31:0] full_b;
      logic [31:0] acc_a;
      logic [31:0] acc_b;
   } lane_type;

   // all result candidates of one axis from the half correction and accel
   function automatic lane_type lane_out(input logic neg, input logic [31:0] mag,
                                         input logic [33:0] acc);
      lane_type    r;
      logic [33:0] full_m;
      logic [33:0] acc_m;
      full_m   = dcp_pkg::sat_mag(neg, {1'b0, mag, 1'b0}, CW);
      acc_m    = dcp_pkg::sat_mag(neg, acc, CW);
      r.half_a = dcp_pkg::to_val(neg, {2'b00, mag});
      r.half_b = dcp_pkg::to_val(!neg, dcp_pkg::sat_mag(!neg, {2'b00, mag}, CW));
      r.full_a = dcp_pkg::to_val(neg, full_m);
      r.full_b = dcp_pkg::to_val(!neg, dcp_pkg::sat_mag(!neg, full_m, CW));
      r.acc_a  = dcp_pkg::to_val(neg, acc_m);
      r.acc_b  = dcp_pkg::to_val(!neg, dcp_pkg::sat_mag(!neg, acc_m, CW));
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // registers
   // --------------------------------------------------------------------------
   logic [dcp_pkg::REG_W-1:0] rest_ff;
   logic [dcp_pkg::REG_W-1:0] dt_ff;
   logic [dcp_pkg::REG_W-1:0] dt_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= dcp_pkg::REST_LENGTH_RST;
         dt_ff   <= dcp_pkg::TIME_STEP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            dcp_pkg::CSR_REST_LENGTH: rest_ff <= csr_data;
            dcp_pkg::CSR_TIME_STEP:   dt_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // a zero step acts as one
   assign dt_eff = (dt_ff == '0) ? 31'd1 : dt_ff;

   // the pipeline never holds off a request
   assign busy = 1'b0;

   // --------------------------------------------------------------------------
   // front: difference, magnitude, squares, sum
   // --------------------------------------------------------------------------
   logic        s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [32:0] s1_dx_ff, s1_dy_ff;
   logic        s1_af_ff, s1_bf_ff;
   logic [32:0] s1_dx_in, s1_dy_in;
   logic [31:0] s2_mx_ff, s2_my_ff;
   logic        s2_nx_ff, s2_ny_ff, s2_af_ff, s2_bf_ff;
   logic [32:0] s2_ndx, s2_ndy;
   logic [63:0] s3_sx_ff, s3_sy_ff;
   sq_side_type s3_side_ff, s4_side_ff;
   logic [dcp_pkg::RAD_W-1:0] s4_rad_ff;

   always_comb begin
      logic signed [31:0] ax, ay, bx, by;
      ax = dcp_pkg::sext(req_data.pos_a_x, CW);
      ay = dcp_pkg::sext(req_data.pos_a_y, CW);
      bx = dcp_pkg::sext(req_data.pos_b_x, CW);
      by = dcp_pkg::sext(req_data.pos_b_y, CW);
      s1_dx_in = {ax[31], ax} - {bx[31], bx};
      s1_dy_in = {ay[31], ay} - {by[31], by};
   end

   assign s2_ndx = 33'd0 - s1_dx_ff;
   assign s2_ndy = 33'd0 - s1_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= start && !busy;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_dx_ff <= s1_dx_in;
      s1_dy_ff <= s1_dy_in;
      s1_af_ff <= req_data.a_fixed;
      s1_bf_ff <= req_data.b_fixed;

      s2_mx_ff <= s1_dx_ff[32] ? s2_ndx[31:0] : s1_dx_ff[31:0];
      s2_my_ff <= s1_dy_ff[32] ? s2_ndy[31:0] : s1_dy_ff[31:0];
      s2_nx_ff <= s1_dx_ff[32];
      s2_ny_ff <= s1_dy_ff[32];
      s2_af_ff <= s1_af_ff;
      s2_bf_ff <= s1_bf_ff;

      s3_sx_ff           <= s2_mx_ff * s2_mx_ff;
      s3_sy_ff           <= s2_my_ff * s2_my_ff;
      s3_side_ff.mag_x   <= s2_mx_ff;
      s3_side_ff.mag_y   <= s2_my_ff;
      s3_side_ff.neg_x   <= s2_nx_ff;
      s3_side_ff.neg_y   <= s2_ny_ff;
      s3_side_ff.a_fixed <= s2_af_ff;
      s3_side_ff.b_fixed <= s2_bf_ff;

      // 65-bit sum of squares, never wraps
      s4_rad_ff  <= {2'b00, s3_sx_ff} + {2'b00, s3_sy_ff};
      s4_side_ff <= s3_side_ff;
   end

   // --------------------------------------------------------------------------
   // distance
   // --------------------------------------------------------------------------
   logic                       sq_vld;
   logic [dcp_pkg::ROOT_W-1:0] sq_len;
   sq_side_type                sq_side;

   dcp_sqrt #(
      .RW (dcp_pkg::ROOT_W),
      .SW ($bits(sq_side_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_rad    (s4_rad_ff),
      .in_side   (s4_side_ff),
      .out_valid (sq_vld),
      .out_root  (sq_len),
      .out_side  (sq_side)
   );

   // --------------------------------------------------------------------------
   // rest length error and setup of the direction divides
   // --------------------------------------------------------------------------
   logic                       d_vld_ff;
   logic [dcp_pkg::ROOT_W-1:0] d_len_ff;
   logic [dcp_pkg::ROOT_W-1:0] d_remx_ff, d_remy_ff;
   logic [dcp_pkg::U_QW-1:0]   d_numx_ff, d_numy_ff;
   ux_side_type                d_side_ff;
   logic                       d_negy_ff;
   logic [33:0]                d_diff, d_diff_neg;

   assign d_diff     = {3'b000, rest_ff} - {1'b0, sq_len};
   assign d_diff_neg = 34'd0 - d_diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= sq_vld;
      end
   end

   // dividend |d| * 2^30: top 31 bits start the remainder, below the length
   always_ff @(posedge clock) begin
      d_len_ff              <= sq_len;
      d_remx_ff             <= {2'b00, sq_side.mag_x[31:1]};
      d_remy_ff             <= {2'b00, sq_side.mag_y[31:1]};
      d_numx_ff             <= {sq_side.mag_x[0], 30'd0};
      d_numy_ff             <= {sq_side.mag_y[0], 30'd0};
      d_side_ff.diff_mag    <= d_diff[33] ? d_diff_neg : d_diff;
      d_side_ff.diff_neg    <= d_diff[33];
      d_side_ff.neg_x       <= sq_side.neg_x;
      d_side_ff.a_fixed     <= sq_side.a_fixed;
      d_side_ff.b_fixed     <= sq_side.b_fixed;
      d_side_ff.degenerate  <= (sq_len == '0);
      d_negy_ff             <= sq_side.neg_y;
   end

   // --------------------------------------------------------------------------
   // unit direction, one divider per axis
   // --------------------------------------------------------------------------
   logic                     ux_vld;
   logic [dcp_pkg::U_QW-1:0] ux_quo, uy_quo;
   ux_side_type              ux_side;
   logic                     uy_negy;

   dcp_div #(
      .DW (dcp_pkg::ROOT_W),
      .QW (dcp_pkg::U_QW),
      .SW ($bits(ux_side_type))
   ) u_div_ux (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_rem    (d_remx_ff),
      .in_num    (d_numx_ff),
      .in_den    (d_len_ff),
      .in_side   (d_side_ff),
      .out_valid (ux_vld),
      .out_quo   (ux_quo),
      .out_side  (ux_side)
   );

   dcp_div #(
      .DW (dcp_pkg::ROOT_W),
      .QW (dcp_pkg::U_QW),
      .SW (1)
   ) u_div_uy (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_vld_ff),
      .in_rem    (d_remy_ff),
      .in_num    (d_numy_ff),
      .in_den    (d_len_ff),
      .in_side   (d_negy_ff),
      .out_valid (),
      .out_quo   (uy_quo),
      .out_side  (uy_negy)
   );

   // --------------------------------------------------------------------------
   // half correction: u * |diff| / 2^31 in two partial products, then clip
   // --------------------------------------------------------------------------
   logic        m1_vld_ff, m2_vld_ff;
   logic [47:0] m1_plx_ff, m1_phx_ff, m1_ply_ff, m1_phy_ff;
   flag_type    m1_flags_ff, m2_flags_ff;
   logic [64:0] m2_prod_x, m2_prod_y;
   logic [33:0] m2_clip_x, m2_clip_y;
   logic [31:0] m2_mx_ff, m2_my_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= ux_vld;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   assign m2_prod_x = {m1_phx_ff, 17'd0} + {17'd0, m1_plx_ff};
   assign m2_prod_y = {m1_phy_ff, 17'd0} + {17'd0, m1_ply_ff};
   assign m2_clip_x = dcp_pkg::sat_mag(m1_flags_ff.nd_neg_x, m2_prod_x[64:31], CW);
   assign m2_clip_y = dcp_pkg::sat_mag(m1_flags_ff.nd_neg_y, m2_prod_y[64:31], CW);

   always_ff @(posedge clock) begin
      m1_plx_ff              <= ux_quo * ux_side.diff_mag[16:0];
      m1_phx_ff              <= ux_quo * ux_side.diff_mag[33:17];
      m1_ply_ff              <= uy_quo * ux_side.diff_mag[16:0];
      m1_phy_ff              <= uy_quo * ux_side.diff_mag[33:17];
      m1_flags_ff.nd_neg_x   <= ux_side.neg_x ^ ux_side.diff_neg;
      m1_flags_ff.nd_neg_y   <= uy_negy ^ ux_side.diff_neg;
      m1_flags_ff.a_fixed    <= ux_side.a_fixed;
      m1_flags_ff.b_fixed    <= ux_side.b_fixed;
      m1_flags_ff.degenerate <= ux_side.degenerate;

      m2_mx_ff    <= m2_clip_x[31:0];
      m2_my_ff    <= m2_clip_y[31:0];
      m2_flags_ff <= m1_flags_ff;
   end

   // --------------------------------------------------------------------------
   // acceleration, first divide by dt
   // --------------------------------------------------------------------------
   logic                      a1_vld;
   logic [dcp_pkg::A1_QW-1:0] a1_qx, a1_qy;
   a1_side_type               a1_in_side, a1_side;
   logic [31:0]               a1_mag_y;

   assign a1_in_side.nd_mag_x = m2_mx_ff;
   assign a1_in_side.flags    = m2_flags_ff;

   dcp_div #(
      .DW (dcp_pkg::REG_W),
      .QW (dcp_pkg::A1_QW),
      .SW ($bits(a1_side_type))
   ) u_div_a1x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_vld_ff),
      .in_rem    ('0),
      .in_num    ({m2_mx_ff, 16'd0}),
      .in_den    (dt_eff),
      .in_side   (a1_in_side),
      .out_valid (a1_vld),
      .out_quo   (a1_qx),
      .out_side  (a1_side)
   );

   dcp_div #(
      .DW (dcp_pkg::REG_W),
      .QW (dcp_pkg::A1_QW),
      .SW (32)
   ) u_div_a1y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_vld_ff),
      .in_rem    ('0),
      .in_num    ({m2_my_ff, 16'd0}),
      .in_den    (dt_eff),
      .in_side   (m2_my_ff),
      .out_valid (),
      .out_quo   (a1_qy),
      .out_side  (a1_mag_y)
   );

   // --------------------------------------------------------------------------
   // overflow check: q * 2^16 / dt reaches 2^32 exactly when q / 2^16 >= dt
   // --------------------------------------------------------------------------
   logic                      o_vld_ff;
   logic                      o_ovfx, o_ovfy;
   logic [dcp_pkg::REG_W-1:0] o_remx_ff, o_remy_ff;
   logic [dcp_pkg::A2_QW-1:0] o_numx_ff, o_numy_ff;
   a2_side_type               o_side_ff;
   a2y_side_type              o_sidey_ff;

   assign o_ovfx = (a1_qx[47:16] >= {1'b0, dt_eff});
   assign o_ovfy = (a1_qy[47:16] >= {1'b0, dt_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else begin
         o_vld_ff <= a1_vld;
      end
   end

   always_ff @(posedge clock) begin
      o_remx_ff           <= o_ovfx ? '0 : a1_qx[46:16];
      o_remy_ff           <= o_ovfy ? '0 : a1_qy[46:16];
      o_numx_ff           <= {a1_qx[15:0], 16'd0};
      o_numy_ff           <= {a1_qy[15:0], 16'd0};
      o_side_ff.nd_mag_x  <= a1_side.nd_mag_x;
      o_side_ff.flags     <= a1_side.flags;
      o_side_ff.ovf_x     <= o_ovfx;
      o_sidey_ff.nd_mag_y <= a1_mag_y;
      o_sidey_ff.ovf_y    <= o_ovfy;
   end

   // --------------------------------------------------------------------------
   // acceleration, second divide by dt
   // --------------------------------------------------------------------------
   logic                      a2_vld;
   logic [dcp_pkg::A2_QW-1:0] a2_qx, a2_qy;
   a2_side_type               a2_side;
   a2y_side_type              a2_sidey;

   dcp_div #(
      .DW (dcp_pkg::REG_W),
      .QW (dcp_pkg::A2_QW),
      .SW ($bits(a2_side_type))
   ) u_div_a2x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (o_vld_ff),
      .in_rem    (o_remx_ff),
      .in_num    (o_numx_ff),
      .in_den    (dt_eff),
      .in_side   (o_side_ff),
      .out_valid (a2_vld),
      .out_quo   (a2_qx),
      .out_side  (a2_side)
   );

   dcp_div #(
      .DW (dcp_pkg::REG_W),
      .QW (dcp_pkg::A2_QW),
      .SW ($bits(a2y_side_type))
   ) u_div_a2y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (o_vld_ff),
      .in_rem    (o_remy_ff),
      .in_num    (o_numy_ff),
      .in_den    (dt_eff),
      .in_side   (o_sidey_ff),
      .out_valid (),
      .out_quo   (a2_qy),
      .out_side  (a2_sidey)
   );

   // --------------------------------------------------------------------------
   // result select and output register
   // --------------------------------------------------------------------------
   logic             rsp_valid_ff;
   dcp_pkg::rsp_type rsp_ff, rsp_in;
   logic [33:0]      f_accx, f_accy;
   lane_type         f_lx, f_ly;
   flag_type         f_flags;

   assign f_flags = a2_side.flags;
   // an overflowed quotient only has to land above every saturation limit
   assign f_accx  = a2_side.ovf_x ? {2'b01, 32'd0} : {2'b00, a2_qx};
   assign f_accy  = a2_sidey.ovf_y ? {2'b01, 32'd0} : {2'b00, a2_qy};
   assign f_lx    = lane_out(f_flags.nd_neg_x, a2_side.nd_mag_x, f_accx);
   assign f_ly    = lane_out(f_flags.nd_neg_y, a2_sidey.nd_mag_y, f_accy);

   always_comb begin
      rsp_in            = '0;
      rsp_in.degenerate = f_flags.degenerate;
      if (!f_flags.degenerate) begin
         if (f_flags.a_fixed) begin
            // a static (wins when both are): b takes the full correction
            rsp_in.move_b_x  = f_lx.full_b;
            rsp_in.move_b_y  = f_ly.full_b;
            rsp_in.accel_b_x = f_lx.acc_b;
            rsp_in.accel_b_y = f_ly.acc_b;
         end else if (f_flags.b_fixed) begin
            rsp_in.move_a_x  = f_lx.full_a;
            rsp_in.move_a_y  = f_ly.full_a;
            rsp_in.accel_a_x = f_lx.acc_a;
            rsp_in.accel_a_y = f_ly.acc_a;
         end else begin
            // both free: half each, b opposite to a
            rsp_in.move_a_x  = f_lx.half_a;
            rsp_in.move_a_y  = f_ly.half_a;
            rsp_in.move_b_x  = f_lx.half_b;
            rsp_in.move_b_y  = f_ly.half_b;
            rsp_in.accel_a_x = f_lx.acc_a;
            rsp_in.accel_a_y = f_ly.acc_a;
            rsp_in.accel_b_x = f_lx.acc_b;
            rsp_in.accel_b_y = f_ly.acc_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= a2_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // --------------------------------------------------------------------------
   // checks
   // --------------------------------------------------------------------------
   // every result traces back to a request exactly one latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching request");

   // coinciding bodies give no motion at all
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.move_a_x == 0 && rsp_data.move_a_y == 0 &&
         rsp_data.move_b_x == 0 && rsp_data.move_b_y == 0 &&
         rsp_data.accel_a_x == 0 && rsp_data.accel_a_y == 0 &&
         rsp_data.accel_b_x == 0 && rsp_data.accel_b_y == 0)
      else $error("degenerate result carries motion");

   // when both bodies move along x they move in opposite directions
   a_opposite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.move_a_x != 0 && rsp_data.move_b_x != 0 |->
         rsp_data.move_a_x[31] != rsp_data.move_b_x[31])
      else $error("bodies moved the same way along x");

endmodule

`default_nettype wire

// File: hw/rtl/dcp_sqrt.sv
// ----------------------------------------------------------------------------
// dcp_sqrt
// pipelined restoring integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_sqrt #(
   parameter int RW = dcp_pkg::ROOT_W,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*RW-1:0] in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output logic [SW-1:0]   out_side
);

   logic            vld_ff  [RW];
   logic [RW:0]     rem_ff  [RW];
   logic [RW-1:0]   root_ff [RW];
   logic [2*RW-1:0] rad_ff  [RW];
   logic [SW-1:0]   side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      localparam int P = RW - 1 - k;   // bit pair taken in this stage

      logic            vld_src;
      logic [RW:0]     rem_src;
      logic [RW-1:0]   root_src;
      logic [2*RW-1:0] rad_src;
      logic [SW-1:0]   side_src;
      logic [RW+2:0]   cur;
      logic [RW+2:0]   sub;
      logic [RW+2:0]   trial;
      logic            take;
      logic [RW:0]     rem_in;
      logic [RW-1:0]   root_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = in_rad;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         cur     = {rem_src, rad_src[2*P +: 2]};
         trial   = {1'b0, root_src, 2'b01};
         take    = (cur >= trial);
         sub     = cur - trial;
         rem_in  = take ? sub[RW:0] : cur[RW:0];
         root_in = {root_src[RW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_src;
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

// File: hw/rtl/dcp_div.sv
// ----------------------------------------------------------------------------
// dcp_div
// pipelined restoring divider, one quotient bit per stage; the starting
// remainder must be below the divisor
// ----------------------------------------------------------------------------
`default_nettype none

module dcp_div #(
   parameter int DW = dcp_pkg::ROOT_W,
   parameter int QW = dcp_pkg::U_QW,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [QW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic          vld_ff  [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] num_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_src;
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] num_src;
      logic [SW-1:0] side_src;
      logic [DW:0]   cur;
      logic [DW:0]   sub;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [QW-1:0] num_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = in_rem;
         assign den_src  = in_den;
         assign num_src  = in_num;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign num_src  = num_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      // dividend bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         cur    = {rem_src, num_src[QW-1]};
         take   = (cur >= {1'b0, den_src});
         sub    = cur - {1'b0, den_src};
         rem_in = take ? sub[DW-1:0] : cur[DW-1:0];
         num_in = {num_src[QW-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         den_ff[k]  <= den_src;
         num_ff[k]  <= num_in;
         side_ff[k] <= side_src;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = num_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

`default_nettype wire
